>>> design/bubble_sort_ascending_core_assert.svh
// Assertion macros for the bubble sort core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BUBBLE_SORT_ASCENDING_CORE_ASSERT_SVH
`define BUBBLE_SORT_ASCENDING_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bubble sort core: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bubble sort core: assertion failed");

`endif

>>> design/bsa_pkg.sv
// Package for the bubble sort core: sequencer states and status codes.
// No dependencies.
package bsa_pkg;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_RD,
        S_LOAD_CARRY,
        S_STEP,
        S_FLUSH,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WT
    } state_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_SORTED = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_OVER   = 2'd2;

endpackage

>>> design/bubble_sort_ascending_core.sv
// Bubble sort core: loads a set into a single-port-per-direction memory, sorts it
// in place and streams it out. Depends on bsa_pkg and bubble_sort_ascending_core_assert.svh.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_       | in        | s_valid / s_ready  | s_value_in[31:0] signed, s_last_in
//  m_       | out       | m_valid / m_ready  | m_value_out[31:0], m_last_out, m_status
//
// Loading accepts one item per cycle while s_valid is high; s_ready is high only
// while a set is loading. Sorting n values runs n-1 passes; pass p loads the last
// entry into a carry, steps down to entry p on the single read and write port and
// writes the carry to entry p-1. Each result item is held until m_ready is high.
// Reset (aresetn low at a clock edge) returns the core to loading an empty set.
`include "bubble_sort_ascending_core_assert.svh"

module bubble_sort_ascending_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_value_in,
    input  logic                 s_last_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_value_out,
    output logic                 m_last_out,
    output logic [1:0]           m_status
);

    localparam int AW = $clog2(DEPTH);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    bsa_pkg::state_t state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] nm1_reg, nm1_next;
    logic [AW-1:0] pass_reg, pass_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] j_reg, j_next;
    logic          empty_reg, empty_next;
    logic [VALUE_WIDTH-1:0] carry_reg, carry_next;
    bsa_pkg::status_t status_reg, status_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_value_reg, m_value_next;
    logic          m_last_reg, m_last_next;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    logic signed [63:0]     in_sx;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [63:0]            out_zx;
    logic                   first_empty;
    logic                   load_end;

    assign in_sx  = 64'(s_value_in);
    assign in_val = in_sx[VALUE_WIDTH-1:0];
    assign out_zx = 64'(rd_data_reg);

    // The set counts as empty when its first stored value is all ones.
    assign first_empty = (count_reg == '0) ? (in_val == '1) : empty_reg;
    assign load_end    = s_last_in || (count_reg == AW'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsa_pkg::S_LOAD;
            count_reg   <= '0;
            pass_reg    <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nm1_reg     <= nm1_next;
        empty_reg   <= empty_next;
        carry_reg   <= carry_next;
        status_reg  <= status_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        nm1_next     = nm1_reg;
        pass_next    = pass_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        empty_next   = empty_reg;
        carry_next   = carry_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        s_ready      = 1'b0;

        case (state_reg)
            bsa_pkg::S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg;
                    wr_data    = in_val;
                    empty_next = first_empty;
                    if (load_end) begin
                        count_next = '0;
                        nm1_next   = count_reg;
                        pass_next  = AW'(1);
                        k_next     = count_reg;
                        j_next     = '0;
                        if (first_empty) begin
                            status_next = bsa_pkg::ST_EMPTY;
                        end else if (s_last_in) begin
                            status_next = bsa_pkg::ST_SORTED;
                        end else begin
                            status_next = bsa_pkg::ST_OVER;
                        end
                        // A single value or an empty set needs no sorting.
                        if (first_empty || count_reg == '0) begin
                            state_next = bsa_pkg::S_OUT_RD;
                        end else begin
                            state_next = bsa_pkg::S_SORT_RD;
                        end
                    end else begin
                        count_next = count_reg + AW'(1);
                    end
                end
            end
            bsa_pkg::S_SORT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = nm1_reg;
                k_next     = nm1_reg;
                state_next = bsa_pkg::S_LOAD_CARRY;
            end
            bsa_pkg::S_LOAD_CARRY: begin
                carry_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = k_reg - AW'(1);
                state_next = bsa_pkg::S_STEP;
            end
            bsa_pkg::S_STEP: begin
                // The carried value is the smallest seen so far in this pass and
                // moves toward the front while it is strictly less.
                wr_en   = 1'b1;
                wr_addr = k_reg;
                if ($signed(carry_reg) < $signed(rd_data_reg)) begin
                    wr_data = rd_data_reg;
                end else begin
                    wr_data    = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (k_reg == pass_reg) begin
                    state_next = bsa_pkg::S_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - AW'(2);
                    k_next     = k_reg - AW'(1);
                end
            end
            bsa_pkg::S_FLUSH: begin
                wr_en   = 1'b1;
                wr_addr = k_reg - AW'(1);
                wr_data = carry_reg;
                if (pass_reg == nm1_reg) begin
                    state_next = bsa_pkg::S_OUT_RD;
                end else begin
                    pass_next  = pass_reg + AW'(1);
                    state_next = bsa_pkg::S_SORT_RD;
                end
            end
            bsa_pkg::S_OUT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = bsa_pkg::S_OUT_LD;
            end
            bsa_pkg::S_OUT_LD: begin
                m_valid_next = 1'b1;
                m_value_next = out_zx[31:0];
                m_last_next  = (j_reg == nm1_reg);
                state_next   = bsa_pkg::S_OUT_WT;
            end
            bsa_pkg::S_OUT_WT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = bsa_pkg::S_LOAD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = j_reg + AW'(1);
                        j_next     = j_reg + AW'(1);
                        state_next = bsa_pkg::S_OUT_LD;
                    end
                end
            end
            default: begin
                state_next = bsa_pkg::S_LOAD;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_value_out = m_value_reg;
    assign m_last_out  = m_last_reg;
    assign m_status    = status_reg;

    `BSA_ASSERT_IMPL(a_load_excludes_output, aclk, aresetn, m_valid_reg, !s_ready)
    `BSA_ASSERT_IMPL(a_no_same_entry_rw, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr)
    `BSA_ASSERT_IMPL(a_step_in_pass, aclk, aresetn, state_reg == bsa_pkg::S_STEP, k_reg >= pass_reg)
    `BSA_ASSERT_IMPL(a_last_at_end, aclk, aresetn, m_valid_reg && m_last_reg, j_reg == nm1_reg)
    `BSA_ASSERT_NEXT(a_last_returns_load, aclk, aresetn,
        m_valid_reg && m_ready && m_last_reg, state_reg == bsa_pkg::S_LOAD)

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for bubble_sort_ascending_core: loads sets of signed values, predicts each
// sorted run and checks every result item in order. Depends on bsa_pkg and the core RTL.
module tb;

    localparam int DEPTH       = 16;
    localparam int TAIL_CYCLES = 64;
    localparam int TIMEOUT_NS  = 1_000_000;

    localparam logic signed [31:0] EMPTY_MARK = -32'sd1;
    localparam logic signed [31:0] VAL_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;

    typedef logic signed [31:0] value_q_t[$];

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        bsa_pkg::status_t   status;
    } run_item_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_value_in  = '0;
    logic               s_last_in   = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [31:0] m_value_out;
    logic               m_last_out;
    logic [1:0]         m_status;

    run_item_t sorted_run_q[$];
    value_q_t  loading_set;

    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;
    int mismatches      = 0;
    int items_accepted  = 0;
    int sets_closed     = 0;
    int results_checked = 0;

    bubble_sort_ascending_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value_in  (s_value_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_last_out  (m_last_out),
        .m_status    (m_status)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT: %0d result items still outstanding", sorted_run_q.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Builds the run that a finished set produces. A set that starts with the
    // empty marker comes back in load order.
    function automatic void close_set(input logic ended_by_last);
        value_q_t           vals;
        logic signed [31:0] t;
        bsa_pkg::status_t   st;
        run_item_t          r;
        int                 n;
        int                 p;
        int                 k;
        vals = loading_set;
        n = vals.size();
        if (vals[0] == EMPTY_MARK) begin
            st = bsa_pkg::ST_EMPTY;
        end else begin
            st = ended_by_last ? bsa_pkg::ST_SORTED : bsa_pkg::ST_OVER;
            for (p = 1; p < n; p++) begin
                for (k = n - 1; k >= p; k--) begin
                    if (vals[k] < vals[k - 1]) begin
                        t = vals[k];
                        vals[k] = vals[k - 1];
                        vals[k - 1] = t;
                    end
                end
            end
        end
        for (k = 0; k < n; k++) begin
            r.value  = vals[k];
            r.last   = (k == n - 1);
            r.status = st;
            sorted_run_q.push_back(r);
        end
        loading_set.delete();
        sets_closed++;
    endfunction

    function automatic void note_accepted(input logic signed [31:0] v, input logic l);
        loading_set.push_back(v);
        items_accepted++;
        if (l || loading_set.size() == DEPTH) begin
            close_set(l);
        end
    endfunction

    // Valid is left high after acceptance; the next call either replaces the
    // payload at once or drops valid for an idle stretch.
    task automatic load_value(input logic signed [31:0] v, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_value_in <= v;
        s_last_in  <= l;
        do @(posedge aclk); while (!s_ready);
        note_accepted(v, l);
    endtask

    task automatic send_set(input value_q_t vals, input logic with_last);
        int i;
        for (i = 0; i < vals.size(); i++) begin
            load_value(vals[i], with_last && (i == vals.size() - 1));
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (sorted_run_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return EMPTY_MARK;
            3:       return '0;
            4, 5:    return $signed($urandom_range(6)) - 32'sd3;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_random_set(input int len, input logic with_last,
                                   input logic first_empty);
        value_q_t vals;
        int       i;
        for (i = 0; i < len; i++) begin
            vals.push_back((i == 0 && first_empty) ? EMPTY_MARK : pick_value());
        end
        send_set(vals, with_last);
    endtask

    task automatic test_single_values();
        value_q_t vals;
        vals = '{32'sd42};
        send_set(vals, 1'b1);
        vals = '{EMPTY_MARK};
        send_set(vals, 1'b1);
    endtask

    task automatic test_extremes();
        value_q_t vals;
        vals = '{VAL_MAX, 32'sd1, VAL_MIN, 32'sd0, EMPTY_MARK, 32'sd1};
        send_set(vals, 1'b1);
    endtask

    task automatic test_empty_marker();
        value_q_t vals;
        vals = '{EMPTY_MARK, 32'sd5, -32'sd3};
        send_set(vals, 1'b1);
    endtask

    // Sixteen values without a last flag: the set is cut at the depth.
    task automatic test_overflow();
        value_q_t vals;
        int       i;
        for (i = 0; i < DEPTH; i++) begin
            vals.push_back(32'sd1000 - i * 32'sd77);
        end
        vals[3] = VAL_MIN;
        vals[9] = VAL_MAX;
        send_set(vals, 1'b0);
    endtask

    task automatic test_full_with_last();
        send_random_set(DEPTH, 1'b1, 1'b0);
    endtask

    task automatic test_empty_overflow();
        send_random_set(DEPTH, 1'b0, 1'b1);
    endtask

    task automatic test_random_sets(input int budget);
        int   sent;
        int   len;
        logic with_last;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 12) begin
                len = DEPTH;
                with_last = 1'($urandom_range(1));
            end else begin
                len = $urandom_range(7, 1);
                with_last = 1'b1;
            end
            send_random_set(len, with_last, $urandom_range(99) < 12);
            sent += len;
        end
    endtask

    initial begin : result_check
        run_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (sorted_run_q.size() == 0) begin
                    flag_mismatch($sformatf("result item %0d with nothing expected: value %0d",
                                            results_checked, m_value_out));
                end else begin
                    want = sorted_run_q.pop_front();
                    if (m_value_out !== want.value || m_last_out !== want.last ||
                        m_status !== want.status) begin
                        flag_mismatch($sformatf(
                            "item %0d: got value %0d last %0b status %0d, want %0d %0b %0d",
                            results_checked, m_value_out, m_last_out, m_status,
                            want.value, want.last, want.status));
                    end
                end
                results_checked++;
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 26;
        sink_idle_pct = 81;
        test_single_values();
        test_extremes();
        test_empty_marker();
        test_overflow();
        pause_until_drained();
        test_full_with_last();
        test_empty_overflow();
        test_random_sets(24);
        pause_until_drained();

        src_idle_pct  = 81;
        sink_idle_pct = 26;
        test_random_sets(24);
        pause_until_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_sets(24);
        pause_until_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sorted_run_q.size() != 0) begin
            flag_mismatch($sformatf("%0d result items never arrived", sorted_run_q.size()));
        end
        $display("Loaded %0d items in %0d sets and checked %0d result items.",
                 items_accepted, sets_closed, results_checked);
        $display("Sets covered single values, extremes, the empty marker and depth cut-offs.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
